>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while rst is high.
`define EFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("efd assertion failed");

// Checked on every rising clk edge, reset cycles included.
`define EFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("efd assertion failed");

`endif

>>> hw/rtl/efd_pkg.sv
package efd_pkg;

  // Largest frame in decoded bytes: header (sync excluded), payload, checksum
  localparam int MAX_FRAME_BYTES = 64;
  // Counter wide enough for the last in-frame index, MAX_FRAME_BYTES-1
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
  // Longest declared length that is still accepted
  localparam logic [8:0] LEN_LIMIT = 9'(MAX_FRAME_BYTES - 4);

  localparam logic [7:0] SYNC_BYTE   = 8'hE0;
  localparam logic [7:0] MARKER_BYTE = 8'hD0;
  localparam logic [7:0] LEN_UNKNOWN = 8'hFF;

  // Decoded byte positions with a meaning of their own
  localparam logic [CNT_W-1:0] IDX_LENGTH  = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_COMMAND = CNT_W'(3);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  // Frame phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_BODY = 3'b010,
    PH_CSUM = 3'b100
  } phase_t;

endpackage

>>> hw/rtl/efd_if.sv
// Raw serial byte channel
interface efd_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

// Decoded result channel
interface efd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic [7:0] command;
  logic       frame_end;

  modport source (output valid, output kind, output frame_byte, output byte_index,
                  output command, output frame_end, input ready);
  modport sink (input valid, input kind, input frame_byte, input byte_index,
                input command, input frame_end, output ready);
endinterface

>>> hw/rtl/escaped_frame_decoder_unit.sv
// Channel  Dir  Payload                                         Handshake
// raw      in   raw_byte[7:0]                                   valid/ready
// res      out  kind[1:0] frame_byte[7:0] byte_index[5:0]       valid/ready
//               command[7:0] frame_end
//
// One raw byte is taken per cycle while res is empty or taken; its result, if any, is shown in the next cycle.
// The per-byte decode is a single stage between the frame state and the
// result register, so throughput is one item per clock while res is taken.
// rst (synchronous) returns the decoder to sync hunting and empties the result.
// A stalled result holds; raw stays ready when the result register will free.
module escaped_frame_decoder_unit
  import efd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  efd_raw_if.sink   raw,
  efd_res_if.source res
);

  // Frame state
  phase_t           phase, phase_next;
  logic             esc, esc_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       length, length_next;
  logic [7:0]       sum, sum_next;
  logic [7:0]       cmd, cmd_next;

  // Result register
  logic             res_valid;
  kind_t            res_kind, kind_next;
  logic [7:0]       res_byte, byte_next;
  logic [5:0]       res_index, index_next;
  logic [7:0]       res_cmd, cmd_out_next;
  logic             res_end, end_next;
  logic             emit;

  logic             take;
  logic [7:0]       b;
  logic [7:0]       v;
  logic [8:0]       count_inc;
  logic [7:0]       len_new;

  assign b    = raw.raw_byte;
  assign take = raw.valid && raw.ready;
  assign raw.ready = !res_valid || res.ready;

  // Per-byte decode
  always_comb begin
    phase_next   = phase;
    esc_next     = esc;
    count_next   = count;
    length_next  = length;
    sum_next     = sum;
    cmd_next     = cmd;
    emit         = 1'b0;
    kind_next    = KIND_BYTE;
    byte_next    = 8'h00;
    index_next   = 6'(count);
    cmd_out_next = 8'h00;
    end_next     = 1'b0;
    v            = esc ? (b + 8'd1) : b;
    count_inc    = 9'(count) + 9'd1;
    len_new      = (count == IDX_LENGTH) ? v : length;

    case (phase)
      PH_BODY, PH_CSUM: begin
        if (!esc && b == MARKER_BYTE) begin
          // marker: dropped, next byte is escaped
          esc_next = 1'b1;
        end else if (phase == PH_CSUM) begin
          // checksum byte closes the frame
          emit         = 1'b1;
          byte_next    = v;
          end_next     = 1'b1;
          kind_next    = (v == sum) ? KIND_GOOD : KIND_BAD;
          cmd_out_next = (v == sum) ? cmd : 8'h00;
          phase_next   = PH_HUNT;
          esc_next     = 1'b0;
          count_next   = '0;
          length_next  = LEN_UNKNOWN;
          sum_next     = 8'h00;
          cmd_next     = 8'h00;
        end else begin
          emit      = 1'b1;
          byte_next = v;
          esc_next  = 1'b0;
          if (count == IDX_LENGTH && {1'b0, v} > LEN_LIMIT) begin
            // declared length too large: abandon the frame
            kind_next   = KIND_LONG;
            end_next    = 1'b1;
            phase_next  = PH_HUNT;
            count_next  = '0;
            length_next = LEN_UNKNOWN;
            sum_next    = 8'h00;
            cmd_next    = 8'h00;
          end else begin
            count_next  = count_inc[CNT_W-1:0];
            sum_next    = sum + v;
            length_next = len_new;
            if (count == IDX_COMMAND) begin
              cmd_next = v;
            end
            if (len_new != LEN_UNKNOWN && count_inc == {1'b0, len_new} + 9'd3) begin
              phase_next = PH_CSUM;
            end
          end
        end
      end
      default: begin
        // hunting for sync; any other byte is dropped
        if (b == SYNC_BYTE) begin
          phase_next  = PH_BODY;
          esc_next    = 1'b0;
          count_next  = '0;
          length_next = LEN_UNKNOWN;
          sum_next    = 8'h00;
          cmd_next    = 8'h00;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      esc    <= 1'b0;
      count  <= '0;
      length <= LEN_UNKNOWN;
      sum    <= 8'h00;
      cmd    <= 8'h00;
    end else if (take) begin
      phase  <= phase_next;
      esc    <= esc_next;
      count  <= count_next;
      length <= length_next;
      sum    <= sum_next;
      cmd    <= cmd_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_kind  <= kind_next;
      res_byte  <= byte_next;
      res_index <= index_next;
      res_cmd   <= cmd_out_next;
      res_end   <= end_next;
    end
  end

  assign res.valid      = res_valid;
  assign res.kind       = res_kind;
  assign res.frame_byte = res_byte;
  assign res.byte_index = res_index;
  assign res.command    = res_cmd;
  assign res.frame_end  = res_end;

endmodule

>>> hw/rtl/efd_checker.sv
`include "assert_macros.svh"

module efd_checker
  import efd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [7:0] frame_byte,
  input logic [5:0] byte_index,
  input logic [7:0] command,
  input logic       frame_end
);

  logic long_item;
  logic stalled;

  assign long_item = res_valid && kind == KIND_LONG;
  assign stalled   = res_valid && !res_ready;

  // frame_end marks exactly the closing kinds
  `EFD_ASSERT(a_end_kind, res_valid |-> (frame_end == (kind != KIND_BYTE)))

  // abandoned frame reports the length position and no command
  `EFD_ASSERT(a_long_fields, long_item |-> (byte_index == 6'd2 && command == 8'h00))

  // only a good frame carries a command
  `EFD_ASSERT(a_cmd_only_good, (res_valid && kind != KIND_GOOD) |-> (command == 8'h00))

  // a stalled item stays put
  `EFD_ASSERT(a_stall_hold, stalled |=> (res_valid && $stable(frame_byte) && $stable(kind)))

  // nothing is offered right after reset
  `EFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid)

endmodule

bind escaped_frame_decoder_unit efd_checker u_efd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .kind       (res.kind),
  .frame_byte (res.frame_byte),
  .byte_index (res.byte_index),
  .command    (res.command),
  .frame_end  (res.frame_end)
);

>>> tb/escaped_frame_decoder_unit_test.sv
module escaped_frame_decoder_unit_test;
  import efd_pkg::*;

  localparam int ITEM_COUNT     = 650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT_RESULT = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 8;

  // One decoded result as the block reports it
  typedef struct {
    kind_t      kind;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic [7:0] command;
    logic       frame_end;
  } decoded_t;

  // One serial byte to send, or a pause until all results are in
  typedef struct {
    logic [7:0] b;
    bit         drain;
  } serial_slot_t;

  logic clk;
  logic rst;

  efd_raw_if raw_ch();
  efd_res_if res_ch();

  escaped_frame_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .raw(raw_ch),
    .res(res_ch)
  );

  serial_slot_t serial_q[$];
  decoded_t     decoded_q[$];

  int err_count = 0;
  int res_count = 0;
  int idle_cycles = 0;

  // Handshake events seen at the rising edge, consumed at the falling edge
  bit raw_fire = 0;
  bit res_fire = 0;

  // Sender and receiver pacing
  bit offering = 0;
  int gap_left = 0;
  int tx_burst = 0;
  int stall_left = 0;
  int rx_burst = 0;
  int hold_left = 0;
  bit held = 0;

  // Decoder state as predicted
  phase_t                fr_phase;
  logic                  esc_armed;
  logic [CNT_W-1:0]      n_decoded;
  logic [7:0]            decl_len;
  logic [7:0]            run_sum;
  logic [7:0]            cmd_byte;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Frame bookkeeping back to its idle values (phase handled by caller)
  function automatic void clear_frame();
    esc_armed = 1'b0;
    n_decoded = '0;
    decl_len  = LEN_UNKNOWN;
    run_sum   = 8'h00;
    cmd_byte  = 8'h00;
  endfunction

  // Predict the result, if any, of one accepted serial byte
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0]       v;
    logic [CNT_W-1:0] idx;
    decoded_t         r;
    logic             good;
    if (fr_phase != PH_BODY && fr_phase != PH_CSUM) begin
      if (b == SYNC_BYTE) begin
        fr_phase = PH_BODY;
        clear_frame();
      end else begin
        fr_phase = PH_HUNT;
      end
      return;
    end
    // unescaped marker only arms the escape
    if (!esc_armed && b == MARKER_BYTE) begin
      esc_armed = 1'b1;
      return;
    end
    v = esc_armed ? b + 8'd1 : b;
    esc_armed = 1'b0;
    if (fr_phase == PH_CSUM) begin
      good         = (v == run_sum);
      r.kind       = good ? KIND_GOOD : KIND_BAD;
      r.frame_byte = v;
      r.byte_index = 6'(n_decoded);
      r.command    = good ? cmd_byte : 8'h00;
      r.frame_end  = 1'b1;
      decoded_q.push_back(r);
      fr_phase = PH_HUNT;
      clear_frame();
      return;
    end
    idx = n_decoded;
    run_sum = run_sum + v;
    n_decoded = n_decoded + 1'b1;
    if (idx == IDX_COMMAND) cmd_byte = v;
    r.frame_byte = v;
    r.byte_index = 6'(idx);
    r.command    = 8'h00;
    if (idx == IDX_LENGTH) begin
      decl_len = v;
      if (9'(v) > LEN_LIMIT) begin
        r.kind      = KIND_LONG;
        r.frame_end = 1'b1;
        decoded_q.push_back(r);
        fr_phase = PH_HUNT;
        clear_frame();
        return;
      end
    end
    if (decl_len != LEN_UNKNOWN && 9'(n_decoded) == 9'(decl_len) + 9'd3) fr_phase = PH_CSUM;
    r.kind      = KIND_BYTE;
    r.frame_end = 1'b0;
    decoded_q.push_back(r);
  endfunction

  // Wait before the next item: random, or zero during a burst
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic void push_raw(input logic [7:0] b);
    serial_slot_t s;
    s.b = b;
    s.drain = 1'b0;
    serial_q.push_back(s);
  endfunction

  function automatic void push_drain();
    serial_slot_t s;
    s.b = 8'h00;
    s.drain = 1'b1;
    serial_q.push_back(s);
  endfunction

  // Data byte with a lean toward the framing codes
  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return MARKER_BYTE;
      1: return SYNC_BYTE;
      2: return MARKER_BYTE - 8'd1;
      3: return SYNC_BYTE - 8'd1;
      4: return 8'hFF;
      default: return 8'h00;
    endcase
  endfunction

  // Send a decoded value, escaped when required or at random
  function automatic void push_coded(input logic [7:0] v, input int esc_pct);
    if (v == MARKER_BYTE || $urandom_range(0, 99) < esc_pct) begin
      push_raw(MARKER_BYTE);
      push_raw(v - 8'd1);
    end else begin
      push_raw(v);
    end
  endfunction

  // Whole frame; an oversized length stops right after the length byte
  function automatic void push_frame(input int len, input bit bad_sum, input int esc_pct);
    logic [7:0] data;
    logic [7:0] sum;
    int         n_bytes;
    push_raw(SYNC_BYTE);
    sum = 8'h00;
    n_bytes = (len > LEN_LIMIT) ? 3 : len + 3;
    for (int i = 0; i < n_bytes; i++) begin
      data = (i == 2) ? 8'(len) : rand_data();
      push_coded(data, esc_pct);
      sum = sum + data;
    end
    if (len > LEN_LIMIT) return;
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    push_coded(sum, esc_pct);
  endfunction

  // Driver: one item offered at a time, changed at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (raw_fire) begin
        raw_fire = 1'b0;
        offering = 1'b0;
        gap_left = (hold_left > 0) ? 0 : draw_wait(tx_burst);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (serial_q.size() > 0) begin
          if (serial_q[0].drain) begin
            if (decoded_q.size() == 0) void'(serial_q.pop_front());
          end else begin
            raw_ch.raw_byte <= serial_q[0].b;
            void'(serial_q.pop_front());
            offering = 1'b1;
          end
        end
      end
      raw_ch.valid <= offering;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst) begin
      if (res_fire) begin
        res_fire = 1'b0;
        stall_left = draw_wait(rx_burst);
      end
      if (!held && res_count >= HOLD_AT_RESULT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check accepted results, predict accepted inputs
  always @(posedge clk) begin
    decoded_t e;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        res_fire = 1'b1;
        res_count++;
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: kind %0d byte %0h index %0d",
                 res_ch.kind, res_ch.frame_byte, res_ch.byte_index);
          err_count++;
        end else begin
          e = decoded_q.pop_front();
          if (res_ch.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, res_ch.kind);
            err_count++;
          end
          if (res_ch.frame_byte !== e.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", e.frame_byte, res_ch.frame_byte);
            err_count++;
          end
          if (res_ch.byte_index !== e.byte_index) begin
            $error("byte_index: expected %0d, got %0d", e.byte_index, res_ch.byte_index);
            err_count++;
          end
          if (res_ch.command !== e.command) begin
            $error("command: expected %0h, got %0h", e.command, res_ch.command);
            err_count++;
          end
          if (res_ch.frame_end !== e.frame_end) begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, res_ch.frame_end);
            err_count++;
          end
        end
      end
      if (raw_ch.valid && raw_ch.ready) begin
        decode_byte(raw_ch.raw_byte);
        raw_fire = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (raw_ch.valid && raw_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] directed [25];
    int         r;
    int         len;
    bit         mid_drain;
    directed = '{
      // noise while hunting
      8'h00, 8'hFF, 8'hD0,
      // escaped marker, sync as data, zero length, good checksum
      8'hE0, 8'hD0, 8'hCF, 8'hE0, 8'h00, 8'hB0,
      // length one past the limit
      8'hE0, 8'h01, 8'h02, 8'h3D,
      // escaped length reaching 0xFF
      8'hE0, 8'h00, 8'h00, 8'hD0, 8'hFE,
      // marker escaping a marker as command, wrong checksum
      8'hE0, 8'h05, 8'h06, 8'h01, 8'hD0, 8'hD0, 8'hDC
    };
    mid_drain = 1'b0;

    rst = 1'b1;
    raw_ch.valid = 1'b0;
    raw_ch.raw_byte = 8'h00;
    res_ch.ready = 1'b0;
    fr_phase = PH_HUNT;
    clear_frame();

    foreach (directed[i]) push_raw(directed[i]);
    push_drain();

    // Random part: mostly well-formed frames, some noise and broken frames
    while (serial_q.size() < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 19))
          0: len = LEN_LIMIT;
          1, 2: len = $urandom_range(7, LEN_LIMIT - 1);
          default: len = $urandom_range(0, 6);
        endcase
        push_frame(len, $urandom_range(0, 4) == 0, $urandom_range(0, 2) * 20);
      end else if (r < 80) begin
        push_frame($urandom_range(LEN_LIMIT + 1, 255), 1'b0, 20);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 5)) push_raw(8'($urandom_range(0, 255)));
      end else begin
        push_raw(SYNC_BYTE);
        repeat ($urandom_range(0, 4)) push_coded(rand_data(), 30);
      end
      if (!mid_drain && serial_q.size() > ITEM_COUNT / 2) begin
        mid_drain = 1'b1;
        push_drain();
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (serial_q.size() != 0 || offering) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/efd_pkg.sv
hw/rtl/efd_if.sv
hw/rtl/escaped_frame_decoder_unit.sv
hw/rtl/efd_checker.sv
tb/escaped_frame_decoder_unit_test.sv
